### hdl/tpa_pkg.sv
// Shared constants, types and helpers of the typed object pool allocator.
`timescale 1ns / 1ps
package tpa_pkg;

  // Pool geometry
  localparam int NUM_POOLS  = 3;
  localparam int POOL_DEPTH = 256;
  localparam int SLOT_W     = $clog2(POOL_DEPTH);
  localparam int LINK_W     = SLOT_W + 1;
  localparam int CNT_W      = SLOT_W + 1;
  localparam int POOL_W     = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int MEM_DEPTH  = NUM_POOLS * POOL_DEPTH;
  localparam int MEM_AW     = $clog2(MEM_DEPTH);

  // Command queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Port field widths
  localparam int CMD_W      = 3;
  localparam int TYPE_W     = 32;
  localparam int SLOT_IN_W  = 8;
  localparam int STATUS_W   = 2;
  localparam int CAP_W      = 9;
  localparam int ID_W       = 32;
  localparam int LIVE_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Null link: top bit set
  localparam logic [LINK_W-1:0] LINK_NULL = {1'b1, {SLOT_W{1'b0}}};

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIRST = 3'd2;
  localparam logic [CMD_W-1:0] CMD_NEXT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COUNT = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_A     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_B     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_C     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_A      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_B      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_C      = 3'd6;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_FIRST,
    OP_NEXT,
    OP_COUNT,
    OP_ERR
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic [POOL_W-1:0]     pool;
    logic [SLOT_IN_W-1:0]  slot;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic [POOL_W-1:0] pool;
    logic [CNT_W-1:0]  cap;
  } rebuild_t;

  // Flat slot address: pool in the upper bits
  function automatic logic [MEM_AW-1:0] mem_addr(input logic [POOL_W-1:0] pool,
                                                 input logic [SLOT_W-1:0] slot);
    return MEM_AW'({pool, slot});
  endfunction

  // Clamp a capacity to the pool depth
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
    logic [CNT_W-1:0] res;
    if (32'(cap) > 32'(POOL_DEPTH)) begin
      res = CNT_W'(POOL_DEPTH);
    end else begin
      res = CNT_W'(cap);
    end
    return res;
  endfunction

endpackage

### hdl/tpa_front.sv
// Front end: configuration registers, type lookup and command classification.
`timescale 1ns / 1ps
module tpa_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tpa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tpa_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [tpa_pkg::CMD_W-1:0]         cmd_i,
  input  logic [tpa_pkg::TYPE_W-1:0]        type_code_i,
  input  logic [tpa_pkg::SLOT_IN_W-1:0]     slot_index_i,
  input  logic                              full_i,
  output logic                              push_o,
  output tpa_pkg::item_t                    item_o,
  output tpa_pkg::rebuild_t                 rebuild_o
);

  logic [tpa_pkg::TYPE_W-1:0] type_limit_q;
  logic [tpa_pkg::TYPE_W-1:0] type_id_q [tpa_pkg::NUM_POOLS];
  logic [tpa_pkg::CAP_W-1:0]  cap_q     [tpa_pkg::NUM_POOLS];
  logic [tpa_pkg::CFG_IDX_W-1:0] type_off;
  logic [tpa_pkg::CFG_IDX_W-1:0] cap_off;
  logic                          type_in_range;
  logic                          cap_in_range;
  logic                          hit;
  logic [tpa_pkg::POOL_W-1:0]    hit_pool;
  logic                          type_ok;

  assign type_off      = cfg_index_i - tpa_pkg::CFG_TYPE_A;
  assign cap_off       = cfg_index_i - tpa_pkg::CFG_CAP_A;
  assign type_in_range = 32'(type_off) < 32'(tpa_pkg::NUM_POOLS);
  assign cap_in_range  = 32'(cap_off) < 32'(tpa_pkg::NUM_POOLS);

  // Store register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_limit_q <= '0;
      for (int p = 0; p < tpa_pkg::NUM_POOLS; p++) begin
        type_id_q[p] <= '0;
        cap_q[p]     <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i) inside
        tpa_pkg::CFG_TYPE_LIMIT: begin
          type_limit_q <= cfg_data_i;
        end
        tpa_pkg::CFG_TYPE_A, tpa_pkg::CFG_TYPE_B, tpa_pkg::CFG_TYPE_C: begin
          if (type_in_range) begin
            type_id_q[tpa_pkg::POOL_W'(type_off)] <= cfg_data_i;
          end
        end
        tpa_pkg::CFG_CAP_A, tpa_pkg::CFG_CAP_B, tpa_pkg::CFG_CAP_C: begin
          if (cap_in_range) begin
            cap_q[tpa_pkg::POOL_W'(cap_off)] <= cfg_data_i[tpa_pkg::CAP_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Request a pool rebuild on any type id or capacity write
  always_comb begin
    rebuild_o = '0;
    if (cfg_we_i) begin
      unique case (cfg_index_i) inside
        tpa_pkg::CFG_TYPE_A, tpa_pkg::CFG_TYPE_B, tpa_pkg::CFG_TYPE_C: begin
          if (type_in_range) begin
            rebuild_o.valid = 1'b1;
            rebuild_o.pool  = tpa_pkg::POOL_W'(type_off);
            rebuild_o.cap   = tpa_pkg::eff_cap(cap_q[tpa_pkg::POOL_W'(type_off)]);
          end
        end
        tpa_pkg::CFG_CAP_A, tpa_pkg::CFG_CAP_B, tpa_pkg::CFG_CAP_C: begin
          if (cap_in_range) begin
            rebuild_o.valid = 1'b1;
            rebuild_o.pool  = tpa_pkg::POOL_W'(cap_off);
            rebuild_o.cap   = tpa_pkg::eff_cap(cfg_data_i[tpa_pkg::CAP_W-1:0]);
          end
        end
        default: ;
      endcase
    end
  end

  // Look up the pool; the lowest matching pool wins
  always_comb begin
    hit      = 1'b0;
    hit_pool = '0;
    for (int p = tpa_pkg::NUM_POOLS - 1; p >= 0; p--) begin
      if (type_id_q[p] == type_code_i) begin
        hit      = 1'b1;
        hit_pool = tpa_pkg::POOL_W'(p);
      end
    end
  end

  assign type_ok = (type_code_i != '0) && (type_code_i < type_limit_q) && hit;

  // Classify the item
  always_comb begin
    item_o.pool = hit_pool;
    item_o.slot = slot_index_i;
    if (!type_ok) begin
      item_o.op = tpa_pkg::OP_ERR;
    end else begin
      unique case (cmd_i)
        tpa_pkg::CMD_ALLOC: item_o.op = tpa_pkg::OP_ALLOC;
        tpa_pkg::CMD_FREE:  item_o.op = tpa_pkg::OP_FREE;
        tpa_pkg::CMD_FIRST: item_o.op = tpa_pkg::OP_FIRST;
        tpa_pkg::CMD_NEXT:  item_o.op = tpa_pkg::OP_NEXT;
        tpa_pkg::CMD_COUNT: item_o.op = tpa_pkg::OP_COUNT;
        default:            item_o.op = tpa_pkg::OP_ERR;
      endcase
    end
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

### hdl/tpa_fifo.sv
// Short queue of classified items between front and back end.
`timescale 1ns / 1ps
module tpa_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tpa_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tpa_pkg::item_t item_o
);

  tpa_pkg::item_t               entry_q [tpa_pkg::FIFO_DEPTH];
  logic [tpa_pkg::FIFO_AW-1:0]  wr_ptr_q;
  logic [tpa_pkg::FIFO_AW-1:0]  rd_ptr_q;
  logic [tpa_pkg::FIFO_AW:0]    count_q;

  assign full_o  = count_q == (tpa_pkg::FIFO_AW + 1)'(tpa_pkg::FIFO_DEPTH);
  assign valid_o = count_q != '0;
  assign item_o  = entry_q[rd_ptr_q];

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### hdl/tpa_back.sv
// Back end: pool state, link memories and the command sequencer.
`timescale 1ns / 1ps
module tpa_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tpa_pkg::rebuild_t              rebuild_i,
  input  logic                           item_valid_i,
  input  tpa_pkg::item_t                 item_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tpa_pkg::STATUS_W-1:0]   status_o,
  output logic [tpa_pkg::SLOT_IN_W-1:0]  result_slot_o,
  output logic                           slot_valid_o,
  output logic [tpa_pkg::ID_W-1:0]       object_id_o,
  output logic [tpa_pkg::LIVE_W-1:0]     live_count_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_EX   = 2'd2;
  localparam logic [1:0] ST_W2   = 2'd3;

  logic [1:0] state_q, state_d;
  tpa_pkg::item_t cur_q;

  // Per-pool state
  logic [tpa_pkg::LINK_W-1:0] free_head_q  [tpa_pkg::NUM_POOLS];
  logic [tpa_pkg::LINK_W-1:0] used_head_q  [tpa_pkg::NUM_POOLS];
  logic [tpa_pkg::CNT_W-1:0]  free_total_q [tpa_pkg::NUM_POOLS];
  logic [tpa_pkg::CNT_W-1:0]  used_total_q [tpa_pkg::NUM_POOLS];
  logic [tpa_pkg::CNT_W-1:0]  fresh_q      [tpa_pkg::NUM_POOLS];
  logic [tpa_pkg::CNT_W-1:0]  cap_q        [tpa_pkg::NUM_POOLS];
  logic [tpa_pkg::ID_W-1:0]   id_q, id_d;

  logic                       pool_we;
  logic [tpa_pkg::LINK_W-1:0] fh_d, uh_d;
  logic [tpa_pkg::CNT_W-1:0]  ft_d, ut_d, fr_d;

  // Pending head back-link after an allocate
  logic [tpa_pkg::LINK_W-1:0] old_head_q, old_head_d;
  logic [tpa_pkg::LINK_W-1:0] new_slot_q, new_slot_d;

  // Memories
  logic [tpa_pkg::LINK_W-1:0] link_mem [tpa_pkg::MEM_DEPTH];
  logic [tpa_pkg::LINK_W-1:0] next_mem [tpa_pkg::MEM_DEPTH];
  logic [tpa_pkg::LINK_W-1:0] prev_mem [tpa_pkg::MEM_DEPTH];
  logic                       use_mem  [tpa_pkg::MEM_DEPTH];
  logic [tpa_pkg::LINK_W-1:0] link_rd_q, next_rd_q, prev_rd_q;
  logic                       use_rd_q;
  logic [tpa_pkg::MEM_AW-1:0] link_ra, use_ra;
  logic                       link_we, next_we, prev_we, use_we;
  logic [tpa_pkg::MEM_AW-1:0] link_wa, next_wa, prev_wa, use_wa;
  logic [tpa_pkg::LINK_W-1:0] link_wd, next_wd, prev_wd;
  logic                       use_wd;

  // Result register
  logic                          out_valid_q;
  logic [tpa_pkg::STATUS_W-1:0]  status_q, res_status;
  logic [tpa_pkg::SLOT_IN_W-1:0] slot_q, res_slot;
  logic                          svalid_q, res_svalid;
  logic [tpa_pkg::ID_W-1:0]      oid_q, res_oid;
  logic [tpa_pkg::LIVE_W-1:0]    live_q, res_live;
  logic                          res_load;

  // Views of the addressed pool
  logic [tpa_pkg::POOL_W-1:0] pl;
  logic [tpa_pkg::LINK_W-1:0] fh, uh;
  logic [tpa_pkg::CNT_W-1:0]  ft, ut, fr, cap, fr_inc, slot_ext;
  logic                       full, slot_ok, fresh_pop;

  assign pl       = cur_q.pool;
  assign fh       = free_head_q[pl];
  assign uh       = used_head_q[pl];
  assign ft       = free_total_q[pl];
  assign ut       = used_total_q[pl];
  assign fr       = fresh_q[pl];
  assign cap      = cap_q[pl];
  assign fr_inc   = fr + 1'b1;
  assign slot_ext = tpa_pkg::CNT_W'(cur_q.slot);
  assign full     = (ft <= tpa_pkg::CNT_W'(1)) || (fh == tpa_pkg::LINK_NULL);
  // Slots at or above the fresh mark were never handed out since rebuild
  assign slot_ok  = (slot_ext < fr) && use_rd_q;
  assign fresh_pop = fh == fr;

  assign link_ra = tpa_pkg::mem_addr(pl, fh[tpa_pkg::SLOT_W-1:0]);
  assign use_ra  = tpa_pkg::mem_addr(pl, tpa_pkg::SLOT_W'(cur_q.slot));

  // Link memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd_q <= link_mem[link_ra];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    next_rd_q <= next_mem[use_ra];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    prev_rd_q <= prev_mem[use_ra];
  end

  always_ff @(posedge clk_i) begin
    if (use_we) begin
      use_mem[use_wa] <= use_wd;
    end
    use_rd_q <= use_mem[use_ra];
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    pop_o      = 1'b0;
    pool_we    = 1'b0;
    fh_d       = fh;
    uh_d       = uh;
    ft_d       = ft;
    ut_d       = ut;
    fr_d       = fr;
    id_d       = id_q;
    old_head_d = old_head_q;
    new_slot_d = new_slot_q;
    link_we    = 1'b0;
    next_we    = 1'b0;
    prev_we    = 1'b0;
    use_we     = 1'b0;
    link_wa    = use_ra;
    next_wa    = use_ra;
    prev_wa    = use_ra;
    use_wa     = use_ra;
    link_wd    = fh;
    next_wd    = uh;
    prev_wd    = tpa_pkg::LINK_NULL;
    use_wd     = 1'b0;
    res_load   = 1'b0;
    res_status = tpa_pkg::STATUS_BAD;
    res_slot   = '0;
    res_svalid = 1'b0;
    res_oid    = '0;
    res_live   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i && (!out_valid_q || out_ready_i)) begin
          pop_o   = 1'b1;
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        case (cur_q.op) inside
          tpa_pkg::OP_ALLOC: begin
            if (full) begin
              res_load   = 1'b1;
              res_status = tpa_pkg::STATUS_FULL;
              state_d    = ST_IDLE;
            end else begin
              state_d = ST_EX;
            end
          end
          tpa_pkg::OP_FREE, tpa_pkg::OP_NEXT: begin
            state_d = ST_EX;
          end
          tpa_pkg::OP_FIRST: begin
            res_load   = 1'b1;
            res_status = tpa_pkg::STATUS_OK;
            if (uh != tpa_pkg::LINK_NULL) begin
              res_slot   = tpa_pkg::SLOT_IN_W'(uh[tpa_pkg::SLOT_W-1:0]);
              res_svalid = 1'b1;
            end
            state_d = ST_IDLE;
          end
          tpa_pkg::OP_COUNT: begin
            res_load   = 1'b1;
            res_status = tpa_pkg::STATUS_OK;
            res_live   = tpa_pkg::LIVE_W'(ut);
            state_d    = ST_IDLE;
          end
          default: begin
            res_load = 1'b1;
            state_d  = ST_IDLE;
          end
        endcase
      end
      ST_EX: begin
        state_d = ST_IDLE;
        case (cur_q.op)
          tpa_pkg::OP_ALLOC: begin
            // Pop the free head and push it on the allocated list
            next_we = 1'b1;
            next_wa = link_ra;
            next_wd = uh;
            prev_we = 1'b1;
            prev_wa = link_ra;
            prev_wd = tpa_pkg::LINK_NULL;
            use_we  = 1'b1;
            use_wa  = link_ra;
            use_wd  = 1'b1;
            pool_we = 1'b1;
            if (fresh_pop) begin
              fh_d = (fr_inc < cap) ? fr_inc : tpa_pkg::LINK_NULL;
              fr_d = fr_inc;
            end else begin
              fh_d = link_rd_q;
            end
            ft_d       = ft - 1'b1;
            ut_d       = ut + 1'b1;
            uh_d       = fh;
            id_d       = id_q + 1'b1;
            res_load   = 1'b1;
            res_status = tpa_pkg::STATUS_OK;
            res_slot   = tpa_pkg::SLOT_IN_W'(fh[tpa_pkg::SLOT_W-1:0]);
            res_svalid = 1'b1;
            res_oid    = id_q + 1'b1;
            if (uh != tpa_pkg::LINK_NULL) begin
              old_head_d = uh;
              new_slot_d = fh;
              state_d    = ST_W2;
            end
          end
          tpa_pkg::OP_FREE: begin
            res_load = 1'b1;
            if (slot_ok) begin
              // Unlink the slot and push it on the free list
              if (next_rd_q != tpa_pkg::LINK_NULL) begin
                prev_we = 1'b1;
                prev_wa = tpa_pkg::mem_addr(pl, next_rd_q[tpa_pkg::SLOT_W-1:0]);
                prev_wd = prev_rd_q;
              end
              pool_we = 1'b1;
              if (prev_rd_q != tpa_pkg::LINK_NULL) begin
                next_we = 1'b1;
                next_wa = tpa_pkg::mem_addr(pl, prev_rd_q[tpa_pkg::SLOT_W-1:0]);
                next_wd = next_rd_q;
              end else begin
                uh_d = next_rd_q;
              end
              use_we     = 1'b1;
              use_wd     = 1'b0;
              link_we    = 1'b1;
              link_wd    = fh;
              fh_d       = tpa_pkg::LINK_W'(cur_q.slot);
              ft_d       = ft + 1'b1;
              ut_d       = ut - 1'b1;
              res_status = tpa_pkg::STATUS_OK;
            end
          end
          tpa_pkg::OP_NEXT: begin
            res_load = 1'b1;
            if (slot_ok) begin
              res_status = tpa_pkg::STATUS_OK;
              if (next_rd_q != tpa_pkg::LINK_NULL) begin
                res_slot   = tpa_pkg::SLOT_IN_W'(next_rd_q[tpa_pkg::SLOT_W-1:0]);
                res_svalid = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      ST_W2: begin
        // Back-link the former head to the new one
        prev_we = 1'b1;
        prev_wa = tpa_pkg::mem_addr(pl, old_head_q[tpa_pkg::SLOT_W-1:0]);
        prev_wd = new_slot_q;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the current item and pending link
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= item_i;
    end
    old_head_q <= old_head_d;
    new_slot_q <= new_slot_d;
  end

  // Control state and pool registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      id_q    <= tpa_pkg::ID_W'(1);
      for (int p = 0; p < tpa_pkg::NUM_POOLS; p++) begin
        free_head_q[p]  <= tpa_pkg::LINK_NULL;
        used_head_q[p]  <= tpa_pkg::LINK_NULL;
        free_total_q[p] <= '0;
        used_total_q[p] <= '0;
        fresh_q[p]      <= '0;
        cap_q[p]        <= '0;
      end
    end else begin
      state_q <= state_d;
      id_q    <= id_d;
      if (rebuild_i.valid) begin
        free_head_q[rebuild_i.pool]  <= (rebuild_i.cap != '0) ? '0 : tpa_pkg::LINK_NULL;
        used_head_q[rebuild_i.pool]  <= tpa_pkg::LINK_NULL;
        free_total_q[rebuild_i.pool] <= rebuild_i.cap;
        used_total_q[rebuild_i.pool] <= '0;
        fresh_q[rebuild_i.pool]      <= '0;
        cap_q[rebuild_i.pool]        <= rebuild_i.cap;
      end else if (pool_we) begin
        free_head_q[pl]  <= fh_d;
        used_head_q[pl]  <= uh_d;
        free_total_q[pl] <= ft_d;
        used_total_q[pl] <= ut_d;
        fresh_q[pl]      <= fr_d;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      status_q <= res_status;
      slot_q   <= res_slot;
      svalid_q <= res_svalid;
      oid_q    <= res_oid;
      live_q   <= res_live;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign result_slot_o = slot_q;
  assign slot_valid_o  = svalid_q;
  assign object_id_o   = oid_q;
  assign live_count_o  = live_q;

endmodule

### hdl/typed_object_pool_allocator.sv
// Top level of the typed object pool allocator.
//
// Input channel (in_valid_i/in_ready_o) carries one command item: cmd_i,
// type_code_i, slot_index_i. Output channel (out_valid_o/out_ready_i)
// returns exactly one result item per command, in order.
// The front end resolves the type id to a pool and queues the item in a
// two-entry queue; the back end runs it against the pool's link memories.
// The back-end sequencer takes one item at a time: first, count, error and
// refused allocate items end in its read state; free and next add an
// execute state (one registered memory read, then the writes); allocate
// adds execute, then a state that back-links any old head.
// Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i; the
// user must do so only while the block is idle, which it does not enforce;
// a type id or capacity write rebuilds that pool at once. After reset all
// pools are empty and unregistered; no clearing pass runs. When the
// receiver stalls, the result waits in the output register and the queue
// keeps taking items until it holds two.
`timescale 1ns / 1ps
module typed_object_pool_allocator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tpa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tpa_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [tpa_pkg::CMD_W-1:0]         cmd_i,
  input  logic [tpa_pkg::TYPE_W-1:0]        type_code_i,
  input  logic [tpa_pkg::SLOT_IN_W-1:0]     slot_index_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tpa_pkg::STATUS_W-1:0]      status_o,
  output logic [tpa_pkg::SLOT_IN_W-1:0]     result_slot_o,
  output logic                              slot_valid_o,
  output logic [tpa_pkg::ID_W-1:0]          object_id_o,
  output logic [tpa_pkg::LIVE_W-1:0]        live_count_o
);

  logic              push;
  logic              fifo_full;
  logic              fifo_valid;
  logic              pop;
  tpa_pkg::item_t    front_item;
  tpa_pkg::item_t    queue_item;
  tpa_pkg::rebuild_t rebuild;

  tpa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .type_code_i  (type_code_i),
    .slot_index_i (slot_index_i),
    .full_i       (fifo_full),
    .push_o       (push),
    .item_o       (front_item),
    .rebuild_o    (rebuild)
  );

  tpa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .item_o  (queue_item)
  );

  tpa_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rebuild_i     (rebuild),
    .item_valid_i  (fifo_valid),
    .item_i        (queue_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .result_slot_o (result_slot_o),
    .slot_valid_o  (slot_valid_o),
    .object_id_o   (object_id_o),
    .live_count_o  (live_count_o)
  );

  // A slot is reported only with an ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && slot_valid_o |-> status_o == tpa_pkg::STATUS_OK)
    else $error("slot reported with error status");

  // A fresh id comes only with an allocated slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (object_id_o != '0) |-> slot_valid_o)
    else $error("object id without slot");

  // A pool never holds all of its slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(live_count_o) < 32'(tpa_pkg::POOL_DEPTH))
    else $error("live count out of range");

  // Nothing is popped while the queue is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> fifo_valid)
    else $error("pop from empty queue");

endmodule

### dv/tb_typed_object_pool_allocator.sv
// Self-checking testbench for the typed object pool allocator.
`timescale 1ns / 1ps
module tb_typed_object_pool_allocator;
  import tpa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_BAD = 3'd5;
  localparam logic [CMD_W-1:0] CMD_TOP = 3'd7;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [SLOT_IN_W-1:0] slot;
    logic                 valid;
    logic [ID_W-1:0]      oid;
    logic [LIVE_W-1:0]    live;
  } pool_result_t;

  // Track pool state and queue the expected reply of each accepted item
  class pool_scoreboard;
    logic [31:0]       type_limit;
    logic [31:0]       tid[NUM_POOLS];
    logic [CAP_W-1:0]  cap[NUM_POOLS];
    logic [LINK_W-1:0] fhead[NUM_POOLS], uhead[NUM_POOLS];
    logic [CNT_W-1:0]  ftot[NUM_POOLS], utot[NUM_POOLS];
    logic [LINK_W-1:0] flink[NUM_POOLS][POOL_DEPTH];
    logic [LINK_W-1:0] unext[NUM_POOLS][POOL_DEPTH];
    logic [LINK_W-1:0] uprev[NUM_POOLS][POOL_DEPTH];
    bit                busy[NUM_POOLS][POOL_DEPTH];
    logic [ID_W-1:0]   id_ctr;
    pool_result_t      replies[$];
    int                errors;

    function new();
      type_limit = 0;
      id_ctr = 1;
      errors = 0;
      for (int p = 0; p < NUM_POOLS; p++) begin
        tid[p] = 0;
        cap[p] = 0;
        rebuild(p);
      end
    endfunction

    function int slots_of(int p);
      return (cap[p] > POOL_DEPTH) ? POOL_DEPTH : int'(cap[p]);
    endfunction

    function void rebuild(int p);
      int c;
      c = slots_of(p);
      for (int i = 0; i < POOL_DEPTH; i++) begin
        flink[p][i] = (i + 1 < c) ? LINK_W'(i + 1) : LINK_NULL;
        unext[p][i] = 0;
        uprev[p][i] = 0;
        busy[p][i] = 0;
      end
      fhead[p] = (c > 0) ? '0 : LINK_NULL;
      uhead[p] = LINK_NULL;
      ftot[p] = CNT_W'(c);
      utot[p] = 0;
    endfunction

    function int lookup(logic [31:0] t);
      if (t == 0 || t >= type_limit) return -1;
      for (int p = 0; p < NUM_POOLS; p++) if (tid[p] == t) return p;
      return -1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (idx)
        CFG_TYPE_LIMIT: type_limit = d;
        CFG_TYPE_A, CFG_TYPE_B, CFG_TYPE_C: begin
          tid[idx - CFG_TYPE_A] = d;
          rebuild(idx - CFG_TYPE_A);
        end
        CFG_CAP_A, CFG_CAP_B, CFG_CAP_C: begin
          cap[idx - CFG_CAP_A] = d[CAP_W-1:0];
          rebuild(idx - CFG_CAP_A);
        end
        default: ;
      endcase
    endfunction

    // Predict the reply of one accepted item
    function void note_item(logic [CMD_W-1:0] cmd, logic [31:0] t, logic [7:0] s);
      pool_result_t r;
      int p;
      bit ok;
      logic [LINK_W-1:0] n, pr, nx;
      r = '{STATUS_BAD, 0, 0, 0, 0};
      p = lookup(t);
      if (p >= 0 && cmd <= CMD_COUNT) begin
        ok = (s < slots_of(p)) && busy[p][s];
        case (cmd)
          CMD_ALLOC: begin
            if (ftot[p] <= 1 || fhead[p] == LINK_NULL) begin
              r.status = STATUS_FULL;
            end else begin
              n = fhead[p];
              fhead[p] = flink[p][n];
              ftot[p]--;
              utot[p]++;
              uprev[p][n] = LINK_NULL;
              unext[p][n] = uhead[p];
              if (uhead[p] != LINK_NULL) uprev[p][uhead[p]] = n;
              uhead[p] = n;
              busy[p][n] = 1;
              id_ctr++;
              r = '{STATUS_OK, n[7:0], 1'b1, id_ctr, 0};
            end
          end
          CMD_FREE: begin
            if (ok) begin
              pr = uprev[p][s];
              nx = unext[p][s];
              if (nx != LINK_NULL) uprev[p][nx] = pr;
              if (pr != LINK_NULL) unext[p][pr] = nx;
              else uhead[p] = nx;
              busy[p][s] = 0;
              flink[p][s] = fhead[p];
              fhead[p] = LINK_W'(s);
              ftot[p]++;
              utot[p]--;
              r.status = STATUS_OK;
            end
          end
          CMD_FIRST: begin
            r.status = STATUS_OK;
            if (uhead[p] != LINK_NULL) begin
              r.slot = uhead[p][7:0];
              r.valid = 1;
            end
          end
          CMD_NEXT: begin
            if (ok) begin
              r.status = STATUS_OK;
              if (unext[p][s] != LINK_NULL) begin
                r.slot = unext[p][s][7:0];
                r.valid = 1;
              end
            end
          end
          default: begin
            r.status = STATUS_OK;
            r.live = utot[p];
          end
        endcase
      end
      replies.push_back(r);
    endfunction

    // Compare one returned reply with the oldest prediction
    function void check_result(pool_result_t got);
      pool_result_t e;
      if (replies.size() == 0) begin
        $display("%0t: unexpected reply status=%0d slot=%0d", $time, got.status, got.slot);
        errors++;
        return;
      end
      e = replies.pop_front();
      if (got.status !== e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.slot !== e.slot) begin
        $display("%0t: result_slot exp %0d got %0d", $time, e.slot, got.slot);
        errors++;
      end
      if (got.valid !== e.valid) begin
        $display("%0t: slot_valid exp %0d got %0d", $time, e.valid, got.valid);
        errors++;
      end
      if (got.oid !== e.oid) begin
        $display("%0t: object_id exp %0h got %0h", $time, e.oid, got.oid);
        errors++;
      end
      if (got.live !== e.live) begin
        $display("%0t: live_count exp %0d got %0d", $time, e.live, got.live);
        errors++;
      end
    endfunction

    // Pick an allocated slot of pool p, or a random index if none
    function logic [7:0] pick_live(int p);
      int cand[$];
      if (p >= 0)
        for (int i = 0; i < POOL_DEPTH; i++) if (busy[p][i]) cand.push_back(i);
      if (cand.size() == 0) return 8'($urandom);
      return 8'(cand[$urandom_range(0, cand.size() - 1)]);
    endfunction
  endclass

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  cfg_we_i = 0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 0;
  logic                  in_ready_o;
  logic [CMD_W-1:0]      cmd_i = '0;
  logic [TYPE_W-1:0]     type_code_i = '0;
  logic [SLOT_IN_W-1:0]  slot_index_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 0;
  logic [STATUS_W-1:0]   status_o;
  logic [SLOT_IN_W-1:0]  result_slot_o;
  logic                  slot_valid_o;
  logic [ID_W-1:0]       object_id_o;
  logic [LIVE_W-1:0]     live_count_o;

  pool_scoreboard sb = new();
  bit hold_req = 0;

  typed_object_pool_allocator dut (.*);

  always #4 clk_i = ~clk_i;

  // Receiver: check replies and stall on a shifting pattern
  int rx_cycle = 0;
  int rx_mode = 0;
  int hold_cnt = 0;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{status_o, result_slot_o, slot_valid_o, object_id_o, live_count_o});
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 2);
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 1) == 1);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    sb.write_reg(idx, d);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one item and hold it until accepted
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [31:0] t, logic [7:0] s);
    cmd_i <= cmd;
    type_code_i <= t;
    slot_index_i <= s;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(cmd, t, s);
  endtask

  // Stop offering and wait until every reply is back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.replies.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_random(int count, bit squeeze);
    int burst;
    int p;
    int pick;
    logic [CMD_W-1:0] cmd;
    logic [31:0] t;
    logic [7:0] s;
    burst = $urandom_range(1, 40);
    for (int k = 0; k < count; k++) begin
      if (squeeze && k == count / 3) hold_req = 1;
      if (squeeze && k == (2 * count) / 3) drain();
      pick = $urandom_range(0, 99);
      if (pick < 35) cmd = CMD_ALLOC;
      else if (pick < 55) cmd = CMD_FREE;
      else if (pick < 65) cmd = CMD_FIRST;
      else if (pick < 82) cmd = CMD_NEXT;
      else if (pick < 94) cmd = CMD_COUNT;
      else cmd = CMD_TYPE_BAD();
      pick = $urandom_range(0, 99);
      if (pick < 85) t = sb.tid[$urandom_range(0, NUM_POOLS - 1)];
      else if (pick < 92) t = $urandom;
      else t = sb.type_limit;
      p = sb.lookup(t);
      s = ($urandom_range(0, 99) < 75) ? sb.pick_live(p) : 8'($urandom);
      send_item(cmd, t, s);
      burst--;
      if (burst == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        burst = $urandom_range(1, 40);
      end
    end
    drain();
  endtask

  function automatic logic [CMD_W-1:0] CMD_TYPE_BAD();
    return CMD_W'($urandom_range(int'(CMD_COUNT) + 1, int'(CMD_TOP)));
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default setup: everything unregistered
    send_item(CMD_ALLOC, 32'd1, 8'd0);
    send_item(CMD_COUNT, 32'd0, 8'd0);
    send_item(CMD_TOP, 32'hFFFF_FFFF, 8'hFF);
    drain();

    // Shared id on pools 0 and 2, lowest wins; tiny pool 0
    write_reg(CFG_TYPE_LIMIT, 32'd16);
    write_reg(CFG_TYPE_A, 32'd3);
    write_reg(CFG_TYPE_B, 32'd9);
    write_reg(CFG_TYPE_C, 32'd3);
    write_reg(CFG_CAP_A, 32'd4);
    write_reg(CFG_CAP_B, 32'd256);
    write_reg(CFG_CAP_C, 32'd1);
    send_item(CMD_FIRST, 32'd3, 8'd0);
    send_item(CMD_ALLOC, 32'd3, 8'd0);
    send_item(CMD_ALLOC, 32'd3, 8'd0);
    send_item(CMD_ALLOC, 32'd3, 8'd0);
    send_item(CMD_ALLOC, 32'd3, 8'd0);
    send_item(CMD_COUNT, 32'd3, 8'd0);
    send_item(CMD_FIRST, 32'd3, 8'd0);
    send_item(CMD_NEXT, 32'd3, 8'd2);
    send_item(CMD_NEXT, 32'd3, 8'd0);
    send_item(CMD_FREE, 32'd3, 8'd1);
    send_item(CMD_FREE, 32'd3, 8'd1);
    send_item(CMD_NEXT, 32'd3, 8'd3);
    send_item(CMD_FREE, 32'd3, 8'd200);
    send_item(CMD_ALLOC, 32'd16, 8'd0);
    send_item(CMD_ALLOC, 32'd5, 8'd0);
    send_item(CMD_ALLOC, 32'd9, 8'hFF);
    send_item(CMD_NEXT, 32'd9, 8'hFF);
    send_item(CMD_COUNT, 32'd9, 8'd0);
    send_item(CMD_BAD, 32'd9, 8'd0);
    drain();
    run_random(350, 1'b1);

    // Extremes of ids and capacities
    write_reg(CFG_TYPE_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_TYPE_A, 32'hFFFF_FFFE);
    write_reg(CFG_TYPE_B, $urandom);
    write_reg(CFG_TYPE_C, 32'h8000_0001);
    write_reg(CFG_CAP_A, 32'h1FF);
    write_reg(CFG_CAP_B, 32'd2);
    write_reg(CFG_CAP_C, 32'd0);
    run_random(350, 1'b1);

    // Random ids and small random capacities
    write_reg(CFG_TYPE_LIMIT, 32'h8000_0000 | $urandom);
    write_reg(CFG_TYPE_A, $urandom_range(1, 1000));
    write_reg(CFG_TYPE_B, $urandom_range(1, 1000));
    write_reg(CFG_TYPE_C, $urandom_range(1, 1000));
    write_reg(CFG_CAP_A, $urandom_range(2, 40));
    write_reg(CFG_CAP_B, $urandom_range(2, 40));
    write_reg(CFG_CAP_C, $urandom_range(2, 40));
    run_random(350, 1'b0);

    // One id at the type limit, never reachable
    write_reg(CFG_TYPE_LIMIT, 32'd64);
    write_reg(CFG_TYPE_A, 32'd1);
    write_reg(CFG_TYPE_B, 32'd63);
    write_reg(CFG_TYPE_C, 32'd64);
    write_reg(CFG_CAP_A, 32'd5);
    write_reg(CFG_CAP_B, 32'd6);
    write_reg(CFG_CAP_C, 32'd7);
    run_random(350, 1'b1);

    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
hdl/tpa_pkg.sv
hdl/tpa_front.sv
hdl/tpa_fifo.sv
hdl/tpa_back.sv
hdl/typed_object_pool_allocator.sv
dv/tb_typed_object_pool_allocator.sv
